// File: sv/gss_pkg.sv
// ----------------------------------------------------------------------------
// Gate schedule start time - shared types and constants
// Field widths, datapath widths, register codes and the records passed
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package gss_pkg;

	localparam int SEC_W   = 48;            // seconds field width
	localparam int NS_W    = 30;            // nanoseconds field width
	localparam int ADV_W   = 26;            // time advance in ns
	localparam int NUM_W   = 32;            // cycle numerator / denominator
	localparam int DSEC_W  = SEC_W - 1;     // past distance, seconds
	localparam int TOT_W   = DSEC_W + NS_W; // past distance, ns
	localparam int X_W     = TOT_W + NUM_W + 1; // scaled distance plus rounding
	localparam int DVS_W   = NUM_W + NS_W;  // numerator times one second in ns
	localparam int BN_W    = 2 * NUM_W;     // remainder times numerator
	localparam int M_W     = NUM_W + NS_W;  // fraction remainder times 1e9
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

	// configuration register indexes
	localparam logic [2:0] CFG_NUM      = 3'd0;
	localparam logic [2:0] CFG_DEN      = 3'd1;
	localparam logic [2:0] CFG_USE_ROWS = 3'd2;
	localparam logic [2:0] CFG_ROWS     = 3'd3;
	localparam logic [2:0] CFG_SPEED    = 3'd4;
	localparam logic [2:0] CFG_PERIOD   = 3'd5;

	// link speed codes; the spare code runs like the ten megabit one
	localparam logic [1:0] SPEED_1G   = 2'd0;
	localparam logic [1:0] SPEED_100M = 2'd1;
	localparam logic [1:0] SPEED_10M  = 2'd2;
	localparam logic [1:0] SPEED_RSVD = 2'd3;

	// derived configuration, recomputed every cycle from the registers
	typedef struct packed {
		logic [ADV_W-1:0] adv;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
		logic [DVS_W-1:0] dvs;
		logic [DVS_W-1:0] dvs_m1;
		logic             skip;
	} cfg_t;

	// classified request, front end to back end
	typedef struct packed {
		logic              past;
		logic              adj;
		logic [SEC_W-1:0]  ss;
		logic [NS_W-1:0]   sn;
		logic [SEC_W-1:0]  nsec;
		logic [DSEC_W-1:0] dsec;
		logic [NS_W-1:0]   dns;
	} rec_t;

	// fields that ride along the back-end pipeline
	typedef struct packed {
		logic             vld;
		logic             past;
		logic             adj;
		logic [SEC_W-1:0] ss;
		logic [NS_W-1:0]  sn;
		logic [SEC_W-1:0] nsec;
	} side_t;

endpackage

// File: sv/gss_front.sv
// ----------------------------------------------------------------------------
// Gate schedule start time - front end
// Normalizes the request, forms base minus advance and classifies it
// against the current time.
// ----------------------------------------------------------------------------
module gss_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gss_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [47:0]             base_seconds,
	input  logic [29:0]             base_nanoseconds,
	input  logic [47:0]             now_seconds,
	input  logic [29:0]             now_nanoseconds,
	input  logic                    full,
	output logic                    push,
	output gss_pkg::rec_t           rec
);
	import gss_pkg::*;

	logic             v_s1, v_s2;
	logic [SEC_W-1:0] bs_s1, ns_s1;
	logic [NS_W-1:0]  bn_s1, nn_s1;
	logic [SEC_W-1:0] ss_s2, nsec_s2;
	logic [NS_W-1:0]  sn_s2, nn_s2;
	logic             rdy1, rdy2;

	logic             bn_hi, nn_hi, bor, nb, past;
	logic [NS_W-1:0]  bn_n, nn_n, adv30, sn_c, dns_c;
	logic [SEC_W-1:0] step, ss_c, nsec_c, d_c;

	assign rdy2     = !v_s2 || !full;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign push     = v_s2 && !full;

	// stage 1 -> 2: normalize, subtract the advance
	assign bn_hi  = bn_s1 >= NS_PER_S;
	assign bn_n   = bn_hi ? bn_s1 - NS_PER_S : bn_s1;
	assign adv30  = NS_W'(cfg.adv);
	assign bor    = bn_n < adv30;
	assign sn_c   = bor ? bn_n + NS_PER_S - adv30 : bn_n - adv30;
	assign step   = (bn_hi && !bor) ? SEC_W'(1) : ((bor && !bn_hi) ? '1 : '0);
	assign ss_c   = bs_s1 + step;
	assign nn_hi  = nn_s1 >= NS_PER_S;
	assign nn_n   = nn_hi ? nn_s1 - NS_PER_S : nn_s1;
	assign nsec_c = ns_s1 + SEC_W'(nn_hi);

	// stage 2: order against now, distance to now
	assign d_c   = nsec_s2 - ss_s2;
	assign past  = (d_c != '0 && !d_c[SEC_W-1]) || (d_c == '0 && sn_s2 <= nn_s2);
	assign nb    = nn_s2 < sn_s2;
	assign dns_c = nb ? nn_s2 + NS_PER_S - sn_s2 : nn_s2 - sn_s2;

	always_comb begin
		rec.past = past;
		rec.adj  = past && !cfg.skip;
		rec.ss   = ss_s2;
		rec.sn   = sn_s2;
		rec.nsec = nsec_s2;
		rec.dsec = DSEC_W'(d_c - SEC_W'(nb));
		rec.dns  = dns_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			bs_s1 <= base_seconds;
			bn_s1 <= base_nanoseconds;
			ns_s1 <= now_seconds;
			nn_s1 <= now_nanoseconds;
		end
		if (rdy2 && v_s1) begin
			ss_s2   <= ss_c;
			sn_s2   <= sn_c;
			nsec_s2 <= nsec_c;
			nn_s2   <= nn_n;
		end
	end

endmodule

// File: sv/gss_fifo.sv
// ----------------------------------------------------------------------------
// Gate schedule start time - request queue
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module gss_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gss_pkg::rec_t wdata,
	input  logic          pop,
	output gss_pkg::rec_t rdata,
	output logic          full,
	output logic          empty
);
	import gss_pkg::*;

	rec_t               mem [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: sv/gss_back.sv
// ----------------------------------------------------------------------------
// Gate schedule start time - back end
// Counts the cycle times needed to reach now with a chain of pipelined
// restoring dividers and adds them to the start time.
// ----------------------------------------------------------------------------
module gss_back (
	input  logic          clk,
	input  logic          arst_n,
	input  gss_pkg::cfg_t cfg,
	input  gss_pkg::rec_t rec,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [47:0]   start_seconds,
	output logic [29:0]   start_nanoseconds,
	output logic [47:0]   change_seconds,
	output logic [29:0]   change_nanoseconds,
	output logic          start_in_past,
	output logic [47:0]   seconds_ahead
);
	import gss_pkg::*;

	logic en;

	side_t             side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t             side_s7, side_s8, side_s9, side_s10, side_s11;
	logic [DSEC_W-1:0] dsec_s1;
	logic [NS_W-1:0]   dns_s1, dns_s2;
	logic [53:0]       pl_s2;
	logic [52:0]       ph_s2;
	logic [TOT_W-1:0]  tot_s3;
	logic [57:0]       p0_s4, p1_s4;
	logic [56:0]       p2_s4;
	logic [83:0]       xa_s5;
	logic [X_W-1:0]    xb_s5, x_s6;
	logic [BN_W-1:0]   bnum_s7, bnum_s8;
	logic [55:0]       pal_s7, pah_s7;
	logic [SEC_W-1:0]  asp_s8, asec_s9, ssum_s10, ss2_s11;
	logic [M_W-1:0]    m_s9;
	logic [NS_W:0]     nsum_s10;
	logic [NS_W-1:0]   sn2_s11;

	logic              out_valid_q, past_q;
	logic [SEC_W-1:0]  ss_q, cs_q, ahead_q;
	logic [NS_W-1:0]   sn_q, cn_q;

	// divider chains
	logic [X_W-1:0]   d1_sh_s [1:X_W];
	logic [DVS_W-1:0] d1_rm_s [1:X_W];
	side_t            d1_sd_s [1:X_W];
	logic [X_W-1:0]   d2_sh_s [1:X_W];
	logic [NUM_W-1:0] d2_rm_s [1:X_W];
	side_t            d2_sd_s [1:X_W];
	logic [BN_W-1:0]  d3_sh_s [1:BN_W];
	logic [NUM_W-1:0] d3_rm_s [1:BN_W];
	logic [SEC_W-1:0] d3_as_s [1:BN_W];
	side_t            d3_sd_s [1:BN_W];
	logic [M_W-1:0]   d4_sh_s [1:M_W];
	logic [NUM_W-1:0] d4_rm_s [1:M_W];
	logic [SEC_W-1:0] d4_as_s [1:M_W];
	side_t            d4_sd_s [1:M_W];

	logic [X_W-1:0]   a_w;
	logic [NUM_W-1:0] b_w, arem_w;
	logic [BN_W-1:0]  q3_w;
	logic [NS_W-1:0]  ans_w;
	logic             ov_w, cov_w;
	logic [NS_W:0]    cn_w;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !empty;

	assign a_w    = d2_sh_s[X_W];
	assign b_w    = d2_rm_s[X_W];
	assign q3_w   = d3_sh_s[BN_W];
	assign arem_w = d3_rm_s[BN_W];
	assign ans_w  = d4_sh_s[M_W][NS_W-1:0];
	assign ov_w   = nsum_s10 >= (NS_W+1)'(NS_PER_S);
	assign cn_w   = (NS_W+1)'(sn2_s11) + (NS_W+1)'(cfg.adv);
	assign cov_w  = cn_w >= (NS_W+1)'(NS_PER_S);

	// side records: control travels with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_s2  <= '0;
			side_s3  <= '0;
			side_s4  <= '0;
			side_s5  <= '0;
			side_s6  <= '0;
			side_s7  <= '0;
			side_s8  <= '0;
			side_s9  <= '0;
			side_s10 <= '0;
			side_s11 <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			side_s1.vld  <= !empty;
			side_s1.past <= rec.past;
			side_s1.adj  <= rec.adj;
			side_s1.ss   <= rec.ss;
			side_s1.sn   <= rec.sn;
			side_s1.nsec <= rec.nsec;
			side_s2  <= side_s1;
			side_s3  <= side_s2;
			side_s4  <= side_s3;
			side_s5  <= side_s4;
			side_s6  <= side_s5;
			side_s7  <= d2_sd_s[X_W];
			side_s8  <= side_s7;
			side_s9  <= d3_sd_s[BN_W];
			side_s10 <= d4_sd_s[M_W];
			side_s11 <= side_s10;
			out_valid_q <= side_s11.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// distance to now in ns, then scaled by the denominator
			dsec_s1 <= rec.dsec;
			dns_s1  <= rec.dns;
			pl_s2   <= 54'(dsec_s1[23:0]) * 54'(NS_PER_S);
			ph_s2   <= 53'(dsec_s1[DSEC_W-1:24]) * 53'(NS_PER_S);
			dns_s2  <= dns_s1;
			tot_s3  <= TOT_W'({ph_s2, 24'd0}) + TOT_W'(pl_s2) + TOT_W'(dns_s2);
			p0_s4   <= 58'(tot_s3[25:0]) * 58'(cfg.den);
			p1_s4   <= 58'(tot_s3[51:26]) * 58'(cfg.den);
			p2_s4   <= 57'(tot_s3[TOT_W-1:52]) * 57'(cfg.den);
			xa_s5   <= 84'(p0_s4) + {p1_s4, 26'd0};
			// add divisor minus one so the quotient rounds up
			xb_s5   <= X_W'({p2_s4, 52'd0}) + X_W'(cfg.dvs_m1);
			x_s6    <= X_W'(xa_s5) + xb_s5;
			// whole cycles split into seconds and a fraction remainder
			bnum_s7 <= BN_W'(b_w) * BN_W'(cfg.num);
			pal_s7  <= 56'(a_w[23:0]) * 56'(cfg.num);
			pah_s7  <= 56'(a_w[47:24]) * 56'(cfg.num);
			asp_s8  <= pal_s7[SEC_W-1:0] + {pah_s7[23:0], 24'd0};
			bnum_s8 <= bnum_s7;
			asec_s9 <= d3_as_s[BN_W] + q3_w[SEC_W-1:0];
			m_s9    <= M_W'(arem_w) * M_W'(NS_PER_S);
			// add the time of the whole cycles, or hold start0 when no cycles apply
			if (d4_sd_s[M_W].adj) begin
				ssum_s10 <= d4_sd_s[M_W].ss + d4_as_s[M_W];
				nsum_s10 <= (NS_W+1)'(d4_sd_s[M_W].sn) + (NS_W+1)'(ans_w);
			end else begin
				ssum_s10 <= d4_sd_s[M_W].ss;
				nsum_s10 <= (NS_W+1)'(d4_sd_s[M_W].sn);
			end
			ss2_s11 <= ssum_s10 + SEC_W'(ov_w);
			sn2_s11 <= ov_w ? NS_W'(nsum_s10 - (NS_W+1)'(NS_PER_S)) : nsum_s10[NS_W-1:0];
			// output register
			ss_q    <= ss2_s11;
			sn_q    <= sn2_s11;
			cs_q    <= ss2_s11 + SEC_W'(cov_w);
			cn_q    <= cov_w ? NS_W'(cn_w - (NS_W+1)'(NS_PER_S)) : cn_w[NS_W-1:0];
			past_q  <= side_s11.past;
			ahead_q <= ss2_s11 - side_s11.nsec;
		end
	end

	// cycle count: ceil(distance * den / (num * 1e9))
	for (genvar i = 0; i < X_W; i++) begin : g_div1
		logic [X_W-1:0]   src_sh;
		logic [DVS_W-1:0] src_rm;
		side_t            src_sd;
		logic [DVS_W:0]   cat, dif;
		logic             ge;
		if (i == 0) begin : g_head
			assign src_sh = x_s6;
			assign src_rm = '0;
			assign src_sd = side_s6;
		end else begin : g_body
			assign src_sh = d1_sh_s[i];
			assign src_rm = d1_rm_s[i];
			assign src_sd = d1_sd_s[i];
		end
		assign cat = {src_rm, src_sh[X_W-1]};
		assign dif = cat - {1'b0, cfg.dvs};
		assign ge  = cat >= {1'b0, cfg.dvs};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d1_sd_s[i+1] <= '0;
			else if (en) d1_sd_s[i+1] <= src_sd;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d1_rm_s[i+1] <= ge ? dif[DVS_W-1:0] : cat[DVS_W-1:0];
				d1_sh_s[i+1] <= {src_sh[X_W-2:0], ge};
			end
		end
	end

	// cycle count over den: whole seconds and remainder
	for (genvar i = 0; i < X_W; i++) begin : g_div2
		logic [X_W-1:0]   src_sh;
		logic [NUM_W-1:0] src_rm;
		side_t            src_sd;
		logic [NUM_W:0]   cat, dif;
		logic             ge;
		if (i == 0) begin : g_head
			assign src_sh = d1_sh_s[X_W];
			assign src_rm = '0;
			assign src_sd = d1_sd_s[X_W];
		end else begin : g_body
			assign src_sh = d2_sh_s[i];
			assign src_rm = d2_rm_s[i];
			assign src_sd = d2_sd_s[i];
		end
		assign cat = {src_rm, src_sh[X_W-1]};
		assign dif = cat - {1'b0, cfg.den};
		assign ge  = cat >= {1'b0, cfg.den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d2_sd_s[i+1] <= '0;
			else if (en) d2_sd_s[i+1] <= src_sd;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d2_rm_s[i+1] <= ge ? dif[NUM_W-1:0] : cat[NUM_W-1:0];
				d2_sh_s[i+1] <= {src_sh[X_W-2:0], ge};
			end
		end
	end

	// remainder times num over den: extra seconds and fraction
	for (genvar i = 0; i < BN_W; i++) begin : g_div3
		logic [BN_W-1:0]  src_sh;
		logic [NUM_W-1:0] src_rm;
		logic [SEC_W-1:0] src_as;
		side_t            src_sd;
		logic [NUM_W:0]   cat, dif;
		logic             ge;
		if (i == 0) begin : g_head
			assign src_sh = bnum_s8;
			assign src_rm = '0;
			assign src_as = asp_s8;
			assign src_sd = side_s8;
		end else begin : g_body
			assign src_sh = d3_sh_s[i];
			assign src_rm = d3_rm_s[i];
			assign src_as = d3_as_s[i];
			assign src_sd = d3_sd_s[i];
		end
		assign cat = {src_rm, src_sh[BN_W-1]};
		assign dif = cat - {1'b0, cfg.den};
		assign ge  = cat >= {1'b0, cfg.den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d3_sd_s[i+1] <= '0;
			else if (en) d3_sd_s[i+1] <= src_sd;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d3_rm_s[i+1] <= ge ? dif[NUM_W-1:0] : cat[NUM_W-1:0];
				d3_sh_s[i+1] <= {src_sh[BN_W-2:0], ge};
				d3_as_s[i+1] <= src_as;
			end
		end
	end

	// fraction to nanoseconds
	for (genvar i = 0; i < M_W; i++) begin : g_div4
		logic [M_W-1:0]   src_sh;
		logic [NUM_W-1:0] src_rm;
		logic [SEC_W-1:0] src_as;
		side_t            src_sd;
		logic [NUM_W:0]   cat, dif;
		logic             ge;
		if (i == 0) begin : g_head
			assign src_sh = m_s9;
			assign src_rm = '0;
			assign src_as = asec_s9;
			assign src_sd = side_s9;
		end else begin : g_body
			assign src_sh = d4_sh_s[i];
			assign src_rm = d4_rm_s[i];
			assign src_as = d4_as_s[i];
			assign src_sd = d4_sd_s[i];
		end
		assign cat = {src_rm, src_sh[M_W-1]};
		assign dif = cat - {1'b0, cfg.den};
		assign ge  = cat >= {1'b0, cfg.den};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d4_sd_s[i+1] <= '0;
			else if (en) d4_sd_s[i+1] <= src_sd;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d4_rm_s[i+1] <= ge ? dif[NUM_W-1:0] : cat[NUM_W-1:0];
				d4_sh_s[i+1] <= {src_sh[M_W-2:0], ge};
				d4_as_s[i+1] <= src_as;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign start_seconds      = ss_q;
	assign start_nanoseconds  = sn_q;
	assign change_seconds     = cs_q;
	assign change_nanoseconds = cn_q;
	assign start_in_past      = past_q;
	assign seconds_ahead      = ahead_q;

endmodule

// File: sv/gate_schedule_start_time_unit.sv
// ----------------------------------------------------------------------------
// Gate schedule start time unit
// Computes the table start time of a time-aware gate schedule from a base
// time and the current time: base minus the time advance, pushed forward by
// the smallest whole number of cycle times that reaches now.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   cfg     | in        | cfg_wr_en            | cfg_index, cfg_wr_data
//   in      | in        | in_valid / in_stall  | base and now, s and ns
//   out     | out       | out_valid / out_stall| start, change, flag, ahead
//
// One request per cycle sustained while out_stall is low; the back end holds
// four bit-per-stage divider chains.
// Reset loads the register defaults; there is no clearing pass.
// An output stall freezes the back end; the four-entry queue and the two
// front stages keep taking transfers until the queue fills.
// ----------------------------------------------------------------------------
module gate_schedule_start_time_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [47:0] base_seconds,
	input  logic [29:0] base_nanoseconds,
	input  logic [47:0] now_seconds,
	input  logic [29:0] now_nanoseconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] start_seconds,
	output logic [29:0] start_nanoseconds,
	output logic [47:0] change_seconds,
	output logic [29:0] change_nanoseconds,
	output logic        start_in_past,
	output logic [47:0] seconds_ahead
);
	import gss_pkg::*;

	logic [NUM_W-1:0] num_q, den_q;
	logic             use_rows_q;
	logic [NS_W-1:0]  rows_q;
	logic [1:0]       speed_q;
	logic [7:0]       period_q;

	logic [NUM_W-1:0] num_eff, den_eff;
	logic [17:0]      k_base;
	logic [20:0]      k_scaled;
	logic [ADV_W-1:0] adv_c;
	logic [DVS_W-1:0] dvs_c;
	cfg_t             cfg_q;

	rec_t             f_rec, q_rec;
	logic             f_push, q_full, q_empty, b_pop;

	// register writes; no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q      <= 32'd1000000;
			den_q      <= 32'd1000000000;
			use_rows_q <= 1'b0;
			rows_q     <= 30'd1000000;
			speed_q    <= SPEED_1G;
			period_q   <= 8'd8;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NUM:      num_q      <= cfg_wr_data;
				CFG_DEN:      den_q      <= cfg_wr_data;
				CFG_USE_ROWS: use_rows_q <= cfg_wr_data[0];
				CFG_ROWS:     rows_q     <= cfg_wr_data[NS_W-1:0];
				CFG_SPEED:    speed_q    <= cfg_wr_data[1:0];
				CFG_PERIOD:   period_q   <= cfg_wr_data[7:0];
				default: ;
			endcase
		end
	end

	// effective cycle time fraction
	assign num_eff = use_rows_q ? NUM_W'(rows_q) : num_q;
	assign den_eff = use_rows_q ? NUM_W'(NS_PER_S) : den_q;
	assign dvs_c   = DVS_W'(num_eff) * DVS_W'(NS_PER_S);

	// time advance: 1540 ns per speed step and clock, and four fifths of that
	// at a 10 ns clock, plus an added term in the period
	always_comb begin
		case (speed_q)
			SPEED_1G: begin
				k_base   = 18'd1540;
				k_scaled = 21'd12320;
			end
			SPEED_100M: begin
				k_base   = 18'd15400;
				k_scaled = 21'd123200;
			end
			default: begin
				k_base   = 18'd154000;
				k_scaled = 21'd1232000;
			end
		endcase
		if (period_q == 8'd10)
			adv_c = ADV_W'(k_scaled) + ADV_W'(100);
		else
			adv_c = ADV_W'(k_base) * ADV_W'(period_q) + ADV_W'(period_q) * ADV_W'(10);
	end

	// hold the derived values in registers for the datapath
	always_ff @(posedge clk) begin
		cfg_q.adv    <= adv_c;
		cfg_q.num    <= num_eff;
		cfg_q.den    <= den_eff;
		cfg_q.dvs    <= dvs_c;
		cfg_q.dvs_m1 <= dvs_c - DVS_W'(1);
		cfg_q.skip   <= (num_eff == '0) || (den_eff == '0);
	end

	gss_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.base_seconds     (base_seconds),
		.base_nanoseconds (base_nanoseconds),
		.now_seconds      (now_seconds),
		.now_nanoseconds  (now_nanoseconds),
		.full             (q_full),
		.push             (f_push),
		.rec              (f_rec)
	);

	gss_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_rec),
		.pop    (b_pop),
		.rdata  (q_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	gss_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.rec                (q_rec),
		.empty              (q_empty),
		.pop                (b_pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.start_seconds      (start_seconds),
		.start_nanoseconds  (start_nanoseconds),
		.change_seconds     (change_seconds),
		.change_nanoseconds (change_nanoseconds),
		.start_in_past      (start_in_past),
		.seconds_ahead      (seconds_ahead)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gate schedule start time unit - testbench
// Drives base/now time requests through the unit under random input gaps and
// output stalls, across several register settings, and checks every result
// transfer against an in-bench calculation of the table start time.
// ----------------------------------------------------------------------------

typedef struct {
	logic [47:0] start_s;
	logic [29:0] start_ns;
	logic [47:0] change_s;
	logic [29:0] change_ns;
	logic        in_past;
	logic [47:0] ahead_s;
} start_time_t;

class start_time_board;
	// shadow copies of the unit's registers
	logic [31:0] cyc_num;
	logic [31:0] cyc_den;
	logic        use_rows;
	logic [29:0] rows_ns;
	logic [1:0]  speed;
	logic [7:0]  period;
	start_time_t pending[$];
	int          errors;

	function void reset_regs();
		cyc_num  = 32'd1000000;
		cyc_den  = 32'd1000000000;
		use_rows = 1'b0;
		rows_ns  = 30'd1000000;
		speed    = gss_pkg::SPEED_1G;
		period   = 8'd8;
		errors   = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			gss_pkg::CFG_NUM:      cyc_num  = val;
			gss_pkg::CFG_DEN:      cyc_den  = val;
			gss_pkg::CFG_USE_ROWS: use_rows = val[0];
			gss_pkg::CFG_ROWS:     rows_ns  = val[29:0];
			gss_pkg::CFG_SPEED:    speed    = val[1:0];
			gss_pkg::CFG_PERIOD:   period   = val[7:0];
			default: ;
		endcase
	endfunction

	// work out the start time for an accepted request and queue it
	function void note_request(logic [47:0] b_s, logic [29:0] b_ns,
	                           logic [47:0] n_s, logic [29:0] n_ns);
		logic [127:0] one_s, mask, fct, adv, bs, bn, ns, nn, ss, sn, d, dsec, dns;
		logic [127:0] num, den, tot, x, ncnt, a, b, asec, arem, ans, cs, cn;
		logic         past;
		start_time_t  r;
		one_s = 128'd1000000000;
		mask  = (128'd1 << 48) - 1;
		fct = (speed == gss_pkg::SPEED_1G) ? 128'd1 :
		      (speed == gss_pkg::SPEED_100M) ? 128'd10 : 128'd100;
		adv = 128'd1540 * fct * 128'(period);
		if (period == 8'd10) adv = adv * 4 / 5;
		adv = adv + 128'd10 * 128'(period);
		bs = 128'(b_s); bn = 128'(b_ns); ns = 128'(n_s); nn = 128'(n_ns);
		// carry an oversized nanosecond value into the seconds
		if (bn >= one_s) begin bn = bn - one_s; bs = (bs + 1) & mask; end
		if (nn >= one_s) begin nn = nn - one_s; ns = (ns + 1) & mask; end
		ss = bs;
		if (bn >= adv) sn = bn - adv;
		else begin
			sn = bn + one_s - adv;
			ss = (ss - 1) & mask;
		end
		d = (ns - ss) & mask;
		past = (d != 0 && !d[47]) || (d == 0 && sn <= nn);
		num = use_rows ? 128'(rows_ns) : 128'(cyc_num);
		den = use_rows ? one_s : 128'(cyc_den);
		if (past && num != 0 && den != 0) begin
			dsec = d;
			if (nn >= sn) dns = nn - sn;
			else begin
				dns = nn + one_s - sn;
				dsec = dsec - 1;
			end
			// N = ceil(distance * den / (num * 1e9))
			tot  = dsec * one_s + dns;
			x    = tot * den + num * one_s - 1;
			ncnt = x / (num * one_s);
			a    = ncnt / den;
			b    = ncnt % den;
			asec = (128'(a[63:0]) * num + (b * num) / den) & ((128'd1 << 64) - 1);
			arem = (b * num) % den;
			ans  = arem * one_s / den;
			ss = (ss + asec) & mask;
			sn = sn + ans;
			if (sn >= one_s) begin sn = sn - one_s; ss = (ss + 1) & mask; end
		end
		cs = ss;
		cn = sn + adv;
		if (cn >= one_s) begin cn = cn - one_s; cs = (cs + 1) & mask; end
		r.start_s   = ss[47:0];
		r.start_ns  = sn[29:0];
		r.change_s  = cs[47:0];
		r.change_ns = cn[29:0];
		r.in_past   = past;
		d           = (ss - ns) & mask;
		r.ahead_s   = d[47:0];
		pending.push_back(r);
	endfunction

	function void check_result(start_time_t got);
		start_time_t want;
		if (pending.size() == 0) begin
			$display("%0t: result transfer with nothing pending", $time);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.start_s !== want.start_s) begin
			$display("%0t: start_seconds expected %0d actual %0d", $time,
				want.start_s, got.start_s);
			errors++;
		end
		if (got.start_ns !== want.start_ns) begin
			$display("%0t: start_nanoseconds expected %0d actual %0d", $time,
				want.start_ns, got.start_ns);
			errors++;
		end
		if (got.change_s !== want.change_s) begin
			$display("%0t: change_seconds expected %0d actual %0d", $time,
				want.change_s, got.change_s);
			errors++;
		end
		if (got.change_ns !== want.change_ns) begin
			$display("%0t: change_nanoseconds expected %0d actual %0d", $time,
				want.change_ns, got.change_ns);
			errors++;
		end
		if (got.in_past !== want.in_past) begin
			$display("%0t: start_in_past expected %0b actual %0b", $time,
				want.in_past, got.in_past);
			errors++;
		end
		if (got.ahead_s !== want.ahead_s) begin
			$display("%0t: seconds_ahead expected %0d actual %0d", $time,
				want.ahead_s, got.ahead_s);
			errors++;
		end
	endfunction
endclass

module testbench;
	import gss_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [47:0] base_seconds;
	logic [29:0] base_nanoseconds;
	logic [47:0] now_seconds;
	logic [29:0] now_nanoseconds;
	logic        out_valid;
	logic        out_stall;
	logic [47:0] start_seconds;
	logic [29:0] start_nanoseconds;
	logic [47:0] change_seconds;
	logic [29:0] change_nanoseconds;
	logic        start_in_past;
	logic [47:0] seconds_ahead;

	start_time_board board;
	bit              quiet;   // no idling on either side when set

	localparam logic [47:0] SEC_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [29:0] NS_MAX  = 30'd999999999;

	gate_schedule_start_time_unit uut (.*);

	// 20 ns clock
	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Note every accepted request; values seen here are the pre-edge ones.
	always @(posedge clk)
		if (arst_n && in_valid && !in_stall)
			board.note_request(base_seconds, base_nanoseconds, now_seconds,
				now_nanoseconds);

	// Check every result transfer against the oldest pending start time.
	always @(posedge clk) begin
		start_time_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.start_s   = start_seconds;
			got.start_ns  = start_nanoseconds;
			got.change_s  = change_seconds;
			got.change_ns = change_nanoseconds;
			got.in_past   = start_in_past;
			got.ahead_s   = seconds_ahead;
			board.check_result(got);
		end
	end

	// Output stall in random bursts, with quiet stretches.
	// A burst ends early once the no-idling stretch begins.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (n) if (!quiet) @(posedge clk);
				out_stall <= 1'b0;
				// release the stall between bursts
			end else if (!quiet && $urandom_range(0, 40) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// Hard limit on run time.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Write one register; only called while the unit is idle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		board.write_reg(idx, val);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] num, logic [31:0] den, logic use_r,
	                        logic [29:0] rows, logic [1:0] spd, logic [7:0] per);
		write_reg(CFG_NUM, num);
		write_reg(CFG_DEN, den);
		write_reg(CFG_USE_ROWS, {31'd0, use_r});
		write_reg(CFG_ROWS, {2'd0, rows});
		write_reg(CFG_SPEED, {30'd0, spd});
		write_reg(CFG_PERIOD, {24'd0, per});
	endtask

	// Present one request and hold it until the transfer happens.
	task automatic send(logic [47:0] bs, logic [29:0] bn, logic [47:0] ns,
	                    logic [29:0] nn);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		base_seconds     <= bs;
		base_nanoseconds <= bn;
		now_seconds      <= ns;
		now_nanoseconds  <= nn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Wait until every pending start time has come back, then let the
	// pipeline settle before any register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_sec();
		return {16'($urandom_range(0, 65535)), $urandom()};
	endfunction

	// Mostly legal nanoseconds; now and then any 30-bit value.
	function automatic logic [29:0] rand_ns();
		if ($urandom_range(0, 15) == 0) return 30'($urandom());
		return 30'($urandom_range(0, 999999999));
	endfunction

	task automatic random_requests(int count);
		logic [47:0] bs, ns;
		logic [29:0] bn, nn;
		for (int i = 0; i < count; i++) begin
			bs = rand_sec();
			bn = rand_ns();
			nn = rand_ns();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: ns = bs + 48'($urandom_range(0, 3));      // near past
				4:          ns = bs + 48'($urandom_range(0, 100000)); // far past
				5:          ns = bs - 48'($urandom_range(0, 2));      // future side
				6:          begin ns = bs; nn = bn; end              // equal times
				7:          begin bs = SEC_MAX - 48'($urandom_range(0, 2));
				                  ns = 48'($urandom_range(0, 3)); end // wrap
				default:    ns = rand_sec();
			endcase
			send(bs, bn, ns, nn);
		end
	endtask

	initial begin
		board = new;
		board.reset_regs();
		quiet            = 1'b0;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = CFG_NUM;
		cfg_wr_data      = 32'd0;
		in_valid         = 1'b0;
		base_seconds     = 48'd0;
		base_nanoseconds = 30'd0;
		now_seconds      = 48'd0;
		now_nanoseconds  = 30'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, equal times, carries, wrap, future start
		send(48'd0, 30'd0, 48'd0, 30'd0);
		send(SEC_MAX, NS_MAX, SEC_MAX, NS_MAX);
		send(48'd0, 30'd0, SEC_MAX, NS_MAX);
		send(SEC_MAX, NS_MAX, 48'd0, 30'd0);
		send(48'd100, 30'h3FFF_FFFF, 48'd100, 30'h3FFF_FFFF);
		send(48'd5, 30'd1000000000, 48'd6, 30'd0);
		send(SEC_MAX, 30'h3FFF_FFFF, 48'd0, 30'h3FFF_FFFF);
		send(48'd10, 30'd500, 48'd10, 30'd0);
		send(48'd10, 30'd20000, 48'd10, 30'd7690);
		send(48'd10, 30'd20000, 48'd10, 30'd7600);
		send(48'd10, 30'd0, 48'd9, NS_MAX);
		send(48'd1000, 30'd0, 48'd2000, 30'd0);
		send(48'h7FFF_FFFF_FFFF, 30'd0, 48'h8000_0000_0000, 30'd0);
		send(48'd0, 30'd0, 48'h8000_0000_0000, 30'd0);
		send(48'd0, 30'd0, 48'h7FFF_FFFF_FFFF, NS_MAX);
		send(48'h5555_5555_5555, 30'h1555_5555, 48'h2AAA_AAAA_AAAA, 30'h2AAA_AAAA);
		send(48'h2AAA_AAAA_AAAA, 30'h2AAA_AAAA, 48'h5555_5555_5555, 30'h1555_5555);
		random_requests(150);
		drain();

		// one cycle of one second, 100M link, period 10 with 4/5 scaling
		set_regs(32'd1, 32'd1, 1'b0, 30'd1000000, SPEED_100M, 8'd10);
		random_requests(150);
		drain();

		// largest cycle time, ten megabit link, longest period
		set_regs(32'hFFFF_FFFF, 32'd1, 1'b0, 30'd1, SPEED_10M, 8'd255);
		random_requests(150);
		drain();

		// tiniest cycle time, spare link speed code, zero period
		set_regs(32'd1, 32'hFFFF_FFFF, 1'b0, 30'd1, SPEED_RSVD, 8'd0);
		send(48'd0, 30'd0, 48'd3, 30'd999);
		random_requests(150);
		drain();

		// row total as cycle time, row total just under one second, period of one
		set_regs(32'd7, 32'd3, 1'b1, NS_MAX, SPEED_1G, 8'd1);
		random_requests(150);
		drain();

		// zero cycle time through the row total, then the numerator, then the denominator
		set_regs(32'd7, 32'd3, 1'b1, 30'd0, SPEED_100M, 8'd8);
		random_requests(60);
		drain();
		set_regs(32'd0, 32'd1000, 1'b0, 30'h3FFF_FFFF, SPEED_10M, 8'd10);
		random_requests(60);
		drain();
		set_regs(32'd1000, 32'd0, 1'b0, 30'd1, SPEED_1G, 8'd8);
		random_requests(40);
		drain();

		// smallest row total, then a last stretch with no idling at all
		set_regs(32'd3, 32'd7, 1'b1, 30'd1, SPEED_1G, 8'd8);
		random_requests(100);
		quiet = 1'b1;
		@(posedge clk);
		random_requests(130);
		drain();

		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
